// ===== sv/spectral_subtraction_gain_macros.svh =====
// Assertion macros for the checker file.
`ifndef SPECTRAL_SUBTRACTION_GAIN_MACROS_SVH
`define SPECTRAL_SUBTRACTION_GAIN_MACROS_SVH

// Same-cycle implication, sampled on clk_i, off while rst_ni is low.
`define SSG_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("ssg check failed");

// Next-cycle implication, sampled on clk_i, off while rst_ni is low.
`define SSG_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("ssg check failed");

`endif

// ===== sv/ssg_pkg.sv =====
// Package for the spectral subtraction gain block: types, sizes, register codes, tables.
package ssg_pkg;

  localparam int MAX_BINS   = 257;
  localparam int MAX_FRAMES = 16;
  localparam int HIST_DEPTH = MAX_BINS * MAX_FRAMES;
  localparam int HIST_AW    = $clog2(HIST_DEPTH);

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  // Register indexes on the configuration port
  localparam logic [CFG_IDX_W-1:0] REG_BINS_IN_USE      = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FRAMES_IN_USE    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_OVER_SUBTRACTION = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_POWER_EXPONENT   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_FLOOR       = 3'd4;

  typedef struct packed {
    logic        [31:0] bin_power;
    logic signed [15:0] bin_real;
    logic signed [15:0] bin_imag;
  } ssg_in_t;

  typedef struct packed {
    logic signed [15:0] out_real;
    logic signed [15:0] out_imag;
    logic        [23:0] applied_gain;
    logic               frame_end;
  } ssg_out_t;

  typedef logic [15:0][31:0] exp_tab_t;

  // Integer square root, bit pair per step
  function automatic logic [63:0] isqrt64(input logic [63:0] x_in);
    logic [63:0] x;
    logic [63:0] r;
    logic [63:0] b;
    x = x_in;
    r = 64'd0;
    for (int i = 0; i < 32; i++) begin
      b = 64'd1 << (62 - 2 * i);
      if (x >= r + b) begin
        x = x - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
    end
    return r;
  endfunction

  // 2^(2^-k) in Q1.30 for k = 1..16, entry k-1
  function automatic exp_tab_t build_exp_tab();
    exp_tab_t    tab;
    logic [63:0] c;
    c = 64'd2 << 30;
    for (int j = 0; j < 16; j++) begin
      c = isqrt64(c << 30);
      tab[j] = c[31:0];
    end
    return tab;
  endfunction

  localparam exp_tab_t EXP2_C = build_exp_tab();

endpackage

// ===== sv/spectral_subtraction_gain.sv =====
// Spectral subtraction gain: noise floor by minimum statistics, gain, bin scaling.
//
// Input channel in_valid_i/in_ready_o carries one spectral bin per word
// (power, real, imag); bins arrive in frame order. Output channel
// out_valid_o/out_ready_i returns one word per bin: the scaled bin, the gain
// and a frame end flag. Configuration writes arrive on cfg_valid_i/cfg_ready_o
// with a register index and data; cfg_ready_o is always high.
// One bin is worked at a time by a sequencer around a single shared
// multiplier and a history memory with one read and one write port.
// Each bin passes a history read and compare for each of the F frames searched,
// two log2 passes, an exp2 pass, and setup and scaling steps; bins whose gain
// is settled early skip the later passes and finish sooner. The block accepts
// no new bin until the last one has gone to the output register.
// After reset the history memory is cleared, one entry a cycle, all 4112
// entries; in_ready_o stays low during that pass. The result waits in an
// output register; while that word is not taken, the following bin's result
// waits in the last step, and the block then returns to idle for the next bin.
module spectral_subtraction_gain (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  ssg_pkg::ssg_in_t                  in_data_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output ssg_pkg::ssg_out_t                 out_data_o,
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [ssg_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  logic [ssg_pkg::CFG_DATA_W-1:0]    cfg_data_i
);
  import ssg_pkg::*;

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_RD, S_CMP, S_NB, S_NORM, S_MANT, S_SQR, S_LOGD,
    S_ALPHA, S_EXP, S_SHIFT, S_FLOOR, S_SCR, S_SCI, S_OUT
  } state_e;

  state_e state_q;

  // Configuration registers
  logic [8:0]  bins_q;
  logic [4:0]  frames_q;
  logic [15:0] beta_q;
  logic [14:0] alpha_q;
  logic [15:0] floor_q;

  // Frame position
  logic [8:0] bin_q;
  logic [3:0] slot_q;

  // Working registers
  logic [HIST_AW-1:0] clr_addr_q;
  logic [HIST_AW-1:0] rd_addr_q;
  logic [31:0]        rdata_q;
  logic [31:0]        p_q;
  logic signed [15:0] re_q;
  logic signed [15:0] im_q;
  logic               last_q;
  logic [4:0]         step_q;
  logic [31:0]        min_q;
  logic [63:0]        x_q;
  logic [5:0]         e_cnt_q;
  logic [31:0]        m_q;
  logic [15:0]        frac_q;
  logic               log_sel_q;
  logic signed [31:0] lr_q;
  logic signed [31:0] lp_q;
  logic [15:0]        f_q;
  logic [4:0]         ip_q;
  logic [23:0]        g_q;
  logic signed [15:0] res_re_q;
  logic signed [15:0] res_im_q;
  ssg_out_t           out_q;
  logic               out_valid_q;

  // History memory
  logic [31:0] hist_mem [HIST_DEPTH];

  logic               in_acc;
  logic [8:0]         nb_c;
  logic [4:0]         nf_c;
  logic [8:0]         bin_w;
  logic [3:0]         slot_w;
  logic [4:0]         slot_inc;
  logic [HIST_AW-1:0] wr_addr_c;
  logic               mem_we;
  logic [HIST_AW-1:0] mem_wa;
  logic [31:0]        mem_wd;

  logic signed [32:0] mul_a;
  logic signed [32:0] mul_b;
  logic signed [65:0] mul_p;

  logic [47:0]        pa_c;
  logic [6:0]         sh_c;
  logic               top_zero_c;
  logic [31:0]        m2_c;
  logic signed [31:0] logv_c;
  logic signed [65:0] alpha_sh_c;
  logic signed [33:0] lg_c;
  logic signed [33:0] t_c;
  logic [31:0]        gw_c;
  logic signed [65:0] scl_c;
  logic signed [15:0] sat_c;

  assign in_ready_o  = (state_q == S_IDLE);
  assign in_acc      = in_valid_i && in_ready_o;
  assign cfg_ready_o = 1'b1;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // Clamp limits and wrap counters beyond them
  always_comb begin
    if (bins_q < 9'd2) begin
      nb_c = 9'd2;
    end else if (bins_q > 9'(MAX_BINS)) begin
      nb_c = 9'(MAX_BINS);
    end else begin
      nb_c = bins_q;
    end
    if (frames_q == 5'd0) begin
      nf_c = 5'd1;
    end else if (frames_q > 5'(MAX_FRAMES)) begin
      nf_c = 5'(MAX_FRAMES);
    end else begin
      nf_c = frames_q;
    end
    bin_w     = (bin_q >= nb_c) ? 9'd0 : bin_q;
    slot_w    = ({1'b0, slot_q} >= nf_c) ? 4'd0 : slot_q;
    slot_inc  = {1'b0, slot_w} + 5'd1;
    wr_addr_c = HIST_AW'(slot_w) * HIST_AW'(MAX_BINS) + HIST_AW'(bin_w);
  end

  // Memory write port: clearing pass or the new power
  always_comb begin
    mem_we = 1'b0;
    mem_wa = wr_addr_c;
    mem_wd = in_data_i.bin_power;
    if (state_q == S_CLEAR) begin
      mem_we = 1'b1;
      mem_wa = clr_addr_q;
      mem_wd = 32'd0;
    end else if (in_acc) begin
      mem_we = 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      hist_mem[mem_wa] <= mem_wd;
    end
    rdata_q <= hist_mem[rd_addr_q];
  end

  // Select the shared multiplier operands
  always_comb begin
    mul_a = 33'sd0;
    mul_b = 33'sd0;
    unique case (state_q)
      S_NB: begin
        mul_a = $signed({1'b0, min_q});
        mul_b = $signed({17'd0, beta_q});
      end
      S_SQR: begin
        mul_a = $signed({1'b0, m_q});
        mul_b = $signed({1'b0, m_q});
      end
      S_ALPHA: begin
        mul_a = $signed({lp_q[31], lp_q});
        mul_b = $signed({18'd0, alpha_q});
      end
      S_EXP: begin
        mul_a = $signed({1'b0, m_q});
        mul_b = $signed({1'b0, EXP2_C[step_q[3:0]]});
      end
      S_SCR: begin
        mul_a = $signed({{17{re_q[15]}}, re_q});
        mul_b = $signed({9'd0, g_q});
      end
      S_SCI: begin
        mul_a = $signed({{17{im_q[15]}}, im_q});
        mul_b = $signed({9'd0, g_q});
      end
      default: begin
        mul_a = 33'sd0;
        mul_b = 33'sd0;
      end
    endcase
  end

  assign mul_p = mul_a * mul_b;

  // Step arithmetic around the multiplier
  always_comb begin
    pa_c       = {4'd0, p_q, 12'd0};
    sh_c       = 7'd32 >> step_q[2:0];
    top_zero_c = ((x_q >> (7'd64 - sh_c)) == 64'd0);
    m2_c       = mul_p[61:30];
    logv_c     = $signed({10'd0, 6'd63 - e_cnt_q, frac_q});
    alpha_sh_c = mul_p >>> 14;
    lg_c       = $signed({{2{lr_q[31]}}, lr_q}) - $signed(alpha_sh_c[33:0]);
    t_c        = lg_c + 34'sd1048576;
    gw_c       = m_q >> (5'd30 - ip_q);
    scl_c      = (mul_p + 66'sd32768) >>> 16;
    if (scl_c > 66'sd32767) begin
      sat_c = 16'sh7fff;
    end else if (scl_c < -66'sd32768) begin
      sat_c = -16'sh8000;
    end else begin
      sat_c = scl_c[15:0];
    end
  end

  // Sequencer, counters, configuration and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      bins_q      <= 9'd257;
      frames_q    <= 5'd8;
      beta_q      <= 16'd4096;
      alpha_q     <= 15'd16384;
      floor_q     <= 16'd6554;
      bin_q       <= 9'd0;
      slot_q      <= 4'd0;
      clr_addr_q  <= '0;
      rd_addr_q   <= '0;
      p_q         <= 32'd0;
      re_q        <= 16'sd0;
      im_q        <= 16'sd0;
      last_q      <= 1'b0;
      step_q      <= 5'd0;
      min_q       <= 32'd0;
      x_q         <= 64'd0;
      e_cnt_q     <= 6'd0;
      m_q         <= 32'd0;
      frac_q      <= 16'd0;
      log_sel_q   <= 1'b0;
      lr_q        <= 32'sd0;
      lp_q        <= 32'sd0;
      f_q         <= 16'd0;
      ip_q        <= 5'd0;
      g_q         <= 24'd0;
      res_re_q    <= 16'sd0;
      res_im_q    <= 16'sd0;
      out_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      // Take a configuration word
      if (cfg_valid_i) begin
        unique case (cfg_index_i)
          REG_BINS_IN_USE:      bins_q   <= cfg_data_i[8:0];
          REG_FRAMES_IN_USE:    frames_q <= cfg_data_i[4:0];
          REG_OVER_SUBTRACTION: beta_q   <= cfg_data_i;
          REG_POWER_EXPONENT:   alpha_q  <= cfg_data_i[14:0];
          REG_GAIN_FLOOR:       floor_q  <= cfg_data_i;
          default: ;
        endcase
      end

      // Drop the output word once taken; the last step reloads it itself
      if (out_valid_q && out_ready_i && state_q != S_OUT) begin
        out_valid_q <= 1'b0;
      end

      unique case (state_q)
        S_CLEAR: begin
          clr_addr_q <= clr_addr_q + 1'b1;
          if (clr_addr_q == HIST_AW'(HIST_DEPTH - 1)) begin
            state_q <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (in_acc) begin
            p_q       <= in_data_i.bin_power;
            re_q      <= in_data_i.bin_real;
            im_q      <= in_data_i.bin_imag;
            last_q    <= (bin_w == nb_c - 9'd1);
            rd_addr_q <= HIST_AW'(bin_w);
            min_q     <= 32'hffff_ffff;
            step_q    <= 5'd0;
            if (bin_w == nb_c - 9'd1) begin
              bin_q  <= 9'd0;
              slot_q <= (slot_inc >= nf_c) ? 4'd0 : slot_inc[3:0];
            end else begin
              bin_q  <= bin_w + 9'd1;
              slot_q <= slot_w;
            end
            state_q <= S_RD;
          end
        end
        S_RD: begin
          state_q <= S_CMP;
        end
        S_CMP: begin
          if (rdata_q < min_q) begin
            min_q <= rdata_q;
          end
          rd_addr_q <= rd_addr_q + HIST_AW'(MAX_BINS);
          if (step_q == nf_c - 5'd1) begin
            state_q <= S_NB;
          end else begin
            step_q  <= step_q + 5'd1;
            state_q <= S_RD;
          end
        end
        S_NB: begin
          // Residual power after noise removal; none left means zero gain
          if (p_q == 32'd0 || pa_c <= mul_p[47:0]) begin
            g_q     <= 24'd0;
            state_q <= S_FLOOR;
          end else begin
            x_q       <= {16'd0, pa_c - mul_p[47:0]};
            e_cnt_q   <= 6'd0;
            step_q    <= 5'd0;
            log_sel_q <= 1'b0;
            state_q   <= S_NORM;
          end
        end
        S_NORM: begin
          // Normalize by halving shift widths
          if (top_zero_c) begin
            x_q     <= x_q << sh_c;
            e_cnt_q <= e_cnt_q + sh_c[5:0];
          end
          if (step_q == 5'd5) begin
            state_q <= S_MANT;
          end else begin
            step_q <= step_q + 5'd1;
          end
        end
        S_MANT: begin
          m_q     <= {1'b0, x_q[63:33]};
          frac_q  <= 16'd0;
          step_q  <= 5'd0;
          state_q <= S_SQR;
        end
        S_SQR: begin
          // One fraction bit per squaring
          if (m2_c[31]) begin
            frac_q <= {frac_q[14:0], 1'b1};
            m_q    <= {1'b0, m2_c[31:1]};
          end else begin
            frac_q <= {frac_q[14:0], 1'b0};
            m_q    <= m2_c;
          end
          if (step_q == 5'd15) begin
            state_q <= S_LOGD;
          end else begin
            step_q <= step_q + 5'd1;
          end
        end
        S_LOGD: begin
          if (!log_sel_q) begin
            lr_q      <= logv_c - 32'sd2752512;
            x_q       <= {32'd0, p_q};
            e_cnt_q   <= 6'd0;
            step_q    <= 5'd0;
            log_sel_q <= 1'b1;
            state_q   <= S_NORM;
          end else begin
            lp_q    <= logv_c - 32'sd1966080;
            state_q <= S_ALPHA;
          end
        end
        S_ALPHA: begin
          // Log gain: saturate high, zero below range, else split for exp2
          if (lg_c >= 34'sd524288) begin
            g_q     <= 24'hff_ffff;
            state_q <= S_FLOOR;
          end else if (t_c < 34'sd0) begin
            g_q     <= 24'd0;
            state_q <= S_FLOOR;
          end else begin
            ip_q    <= t_c[20:16];
            f_q     <= t_c[15:0];
            m_q     <= 32'd1 << 30;
            step_q  <= 5'd0;
            state_q <= S_EXP;
          end
        end
        S_EXP: begin
          if (f_q[4'd15 - step_q[3:0]]) begin
            m_q <= m2_c;
          end
          if (step_q == 5'd15) begin
            state_q <= S_SHIFT;
          end else begin
            step_q <= step_q + 5'd1;
          end
        end
        S_SHIFT: begin
          g_q     <= (gw_c > 32'h00ff_ffff) ? 24'hff_ffff : gw_c[23:0];
          state_q <= S_FLOOR;
        end
        S_FLOOR: begin
          if (g_q < {8'd0, floor_q}) begin
            g_q <= {8'd0, floor_q};
          end
          state_q <= S_SCR;
        end
        S_SCR: begin
          res_re_q <= sat_c;
          state_q  <= S_SCI;
        end
        S_SCI: begin
          res_im_q <= sat_c;
          state_q  <= S_OUT;
        end
        S_OUT: begin
          // Hold until the output register is free
          if (!out_valid_q || out_ready_i) begin
            out_q.out_real     <= res_re_q;
            out_q.out_imag     <= res_im_q;
            out_q.applied_gain <= g_q;
            out_q.frame_end    <= last_q;
            out_valid_q        <= 1'b1;
            state_q            <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// ===== sv/ssg_checker.sv =====
// Port-level checks for the spectral subtraction gain block, bound to the top level.
`include "spectral_subtraction_gain_macros.svh"

module ssg_checker (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              in_valid_i,
  input logic              in_ready_o,
  input logic              out_valid_o,
  input logic              out_ready_i,
  input ssg_pkg::ssg_out_t out_data_o
);
  import ssg_pkg::*;

  // A stalled output word stays put
  `SSG_ASSERT_NEXT(a_out_hold, out_valid_o && !out_ready_i, out_valid_o && $stable(out_data_o))

  // The sequencer is busy with a bin: no accept right after an accept
  `SSG_ASSERT_NEXT(a_busy_after_accept, in_valid_i && in_ready_o, !in_ready_o)

  // A new word appears only at the end of the busy phase
  `SSG_ASSERT_NOW(a_word_after_busy, $rose(out_valid_o), !$past(in_ready_o))

endmodule

bind spectral_subtraction_gain ssg_checker u_ssg_checker (.*);
